// ----- src/ir_distance_table_interpolator_defines.svh -----
// ---------------------------------------------------------------------------
// IR distance table interpolator - assertion macros
// Shared concurrent assertion forms for the port checker.
// ---------------------------------------------------------------------------
`ifndef IR_DISTANCE_TABLE_INTERPOLATOR_DEFINES_SVH
`define IR_DISTANCE_TABLE_INTERPOLATOR_DEFINES_SVH

// consequent must hold in the cycle after the antecedent
`define IRDTI_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define IRDTI_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ----- src/irdti_pkg.sv -----
// ---------------------------------------------------------------------------
// irdti_pkg
// Types, register codes and constants of the IR distance table interpolator.
// ---------------------------------------------------------------------------
package irdti_pkg;

	localparam int HALF_ENTRIES_DEF = 8;
	localparam int SENSOR_COUNT_DEF = 2;

	localparam logic [7:0] VOLT_SAT   = 8'd255;
	localparam logic [7:0] DIST_FLAT  = 8'd255;
	localparam int         DIST_SCALE = 5;
	localparam int         FRAC_BITS  = 8;
	localparam int         SAT_BASE   = 510;

	// radix-4 restoring divide of a 24-bit dividend
	localparam int DIV_BITS  = 24;
	localparam int DIV_STEPS = DIV_BITS / 2;

	localparam logic REQ_WRITE   = 1'b0;
	localparam logic REQ_CONVERT = 1'b1;

	typedef enum logic [2:0] {
		CFG_VOLTAGE_OFFSET  = 3'd0,
		CFG_BYPASS_MODE     = 3'd1,
		CFG_MIN_DISTANCE    = 3'd2,
		CFG_MAX_DISTANCE    = 3'd3,
		CFG_INFINITE_DIST   = 3'd4
	} cfg_idx_t;

	localparam logic [7:0]  RST_VOLTAGE_OFFSET = 8'd0;
	localparam logic        RST_BYPASS_MODE    = 1'b0;
	localparam logic [14:0] RST_MIN_DISTANCE   = 15'd100;
	localparam logic [10:0] RST_MAX_DISTANCE   = 11'd800;
	localparam logic [14:0] RST_INFINITE_DIST  = 15'd9999;

	typedef struct packed {
		logic [7:0]  voltage_offset;
		logic        bypass_mode;
		logic [14:0] min_distance_mm;
		logic [10:0] max_distance_mm;
		logic [14:0] infinite_distance_mm;
	} cfg_t;

	typedef struct packed {
		logic [7:0] volt;
		logic [7:0] fifths;
	} entry_t;

endpackage

// ----- src/irdti_if.sv -----
// ---------------------------------------------------------------------------
// irdti_req_if / irdti_res_if
// Valid/ready channels for requests and distance results.
// ---------------------------------------------------------------------------
interface irdti_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic       sensor_side;
	logic [3:0] entry_index;
	logic [7:0] entry_voltage;
	logic [7:0] entry_distance;
	logic [9:0] sample;

	modport source (output valid, req_type, sensor_side, entry_index,
		entry_voltage, entry_distance, sample, input ready);
	modport sink (input valid, req_type, sensor_side, entry_index,
		entry_voltage, entry_distance, sample, output ready);
endinterface

interface irdti_res_if;
	logic        valid;
	logic        ready;
	logic [14:0] distance_mm;
	logic        toggle;
	logic        result_side;

	modport source (output valid, distance_mm, toggle, result_side, input ready);
	modport sink (input valid, distance_mm, toggle, result_side, output ready);
endinterface

// ----- src/irdti_table_mem.sv -----
// ---------------------------------------------------------------------------
// irdti_table_mem
// Calibration table storage: one write port, one registered read port.
// ---------------------------------------------------------------------------
module irdti_table_mem #(
	parameter int DEPTH  = 2 * irdti_pkg::SENSOR_COUNT_DEF * irdti_pkg::HALF_ENTRIES_DEF,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_W-1:0]    waddr,
	input  irdti_pkg::entry_t    wdata,
	input  logic [ADDR_W-1:0]    raddr,
	output irdti_pkg::entry_t    rdata
);

	irdti_pkg::entry_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- src/irdti_div.sv -----
// ---------------------------------------------------------------------------
// irdti_div
// Slope divider: (num << 8) / den, two quotient bits per cycle.
// ---------------------------------------------------------------------------
module irdti_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] num,
	input  logic [7:0]  den,
	output logic        done,
	output logic [15:0] quo
);

	localparam int CNT_W = $clog2(irdti_pkg::DIV_STEPS);

	logic                                busy_q;
	logic                                done_q;
	logic [CNT_W-1:0]                    cnt_q;
	logic [irdti_pkg::DIV_BITS-1:0]      dvd_q;
	logic [7:0]                          rem_q;
	logic [7:0]                          den_q;
	logic [15:0]                         quo_q;

	logic [8:0] r1, r1s, r2, r2s;
	logic       ge1, ge2;

	always_comb begin
		r1  = {rem_q, dvd_q[irdti_pkg::DIV_BITS-1]};
		ge1 = r1 >= {1'b0, den_q};
		r1s = ge1 ? r1 - {1'b0, den_q} : r1;
		r2  = {r1s[7:0], dvd_q[irdti_pkg::DIV_BITS-2]};
		ge2 = r2 >= {1'b0, den_q};
		r2s = ge2 ? r2 - {1'b0, den_q} : r2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rem_q  <= '0;
				den_q  <= den;
				dvd_q  <= {num, {irdti_pkg::FRAC_BITS{1'b0}}};
			end else if (busy_q) begin
				rem_q <= r2s[7:0];
				dvd_q <= {dvd_q[irdti_pkg::DIV_BITS-3:0], 2'b00};
				quo_q <= {quo_q[13:0], ge1, ge2};
				if (cnt_q == CNT_W'(irdti_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ----- src/irdti_lookup.sv -----
// ---------------------------------------------------------------------------
// irdti_lookup
// Request sequencer: table writes, pivot read, serial scan, interpolation.
// ---------------------------------------------------------------------------
module irdti_lookup #(
	parameter int HALF_ENTRIES = irdti_pkg::HALF_ENTRIES_DEF,
	parameter int SENSOR_COUNT = irdti_pkg::SENSOR_COUNT_DEF,
	parameter int ADDR_W       = $clog2(2 * HALF_ENTRIES * SENSOR_COUNT)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  irdti_pkg::cfg_t      cfg,
	irdti_req_if.sink            req,
	irdti_res_if.source          res,
	output logic                 mem_we,
	output logic [ADDR_W-1:0]    mem_waddr,
	output irdti_pkg::entry_t    mem_wdata,
	output logic [ADDR_W-1:0]    mem_raddr,
	input  irdti_pkg::entry_t    mem_rdata
);

	localparam int ENTRY_COUNT = 2 * HALF_ENTRIES;
	localparam int IDX_W       = $clog2(ENTRY_COUNT);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PIVOT,
		ST_SCAN,
		ST_DIV,
		ST_MUL,
		ST_FIN,
		ST_CHK,
		ST_OUT
	} state_t;

	state_t             state_q;
	logic               side_q;
	logic [7:0]         volt_q;
	logic [IDX_W-1:0]   i_q;
	logic [IDX_W-1:0]   last_q;
	irdti_pkg::entry_t  prev_q;
	logic [23:0]        prod_q;
	logic [7:0]         d_q;
	logic [14:0]        dist_q;
	logic [SENSOR_COUNT-1:0] toggle_q;

	logic               res_valid_q;
	logic [14:0]        res_dist_q;
	logic               res_toggle_q;
	logic               res_side_q;

	logic               accept, side_ok, idx_ok, sat, tog_cur, res_load;
	logic [7:0]         volt_in, xd;
	logic               go_upper, found, flat;
	logic [IDX_W-1:0]   nxt;
	logic               div_start, div_done;
	logic [15:0]        div_num, div_quo;
	logic [7:0]         div_den;
	logic [10:0]        d5;

	function automatic logic [ADDR_W-1:0] side_base(input logic side);
		side_base = side ? ADDR_W'(ENTRY_COUNT) : '0;
	endfunction

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && (state_q == ST_IDLE);
	assign side_ok   = (SENSOR_COUNT > 1) || !req.sensor_side;
	assign idx_ok    = 8'(req.entry_index) < 8'(ENTRY_COUNT);

	assign sat = {1'b0, req.sample} >
		(11'(irdti_pkg::SAT_BASE) + {3'b000, cfg.voltage_offset});
	assign volt_in = sat ? irdti_pkg::VOLT_SAT : req.sample[8:1] - cfg.voltage_offset;

	assign go_upper = volt_q > mem_rdata.volt;
	assign found    = volt_q > mem_rdata.volt;
	assign flat     = prev_q.volt == mem_rdata.volt;
	assign nxt      = (i_q == last_q) ? i_q : i_q + 1'b1;
	assign xd       = prev_q.volt - volt_q;
	assign d5       = {d_q, 2'b00} + {3'b000, d_q};

	// result register takes the answer once it is free
	assign res_load = (state_q == ST_OUT) && (!res_valid_q || res.ready);

	// table write port
	assign mem_we    = accept && (req.req_type == irdti_pkg::REQ_WRITE) && side_ok && idx_ok;
	assign mem_waddr = side_base(req.sensor_side) + ADDR_W'(8'(req.entry_index));
	assign mem_wdata = '{volt: req.entry_voltage, fifths: req.entry_distance};

	always_comb begin
		case (state_q)
			ST_IDLE:  mem_raddr = side_base(req.sensor_side) + ADDR_W'(HALF_ENTRIES - 1);
			ST_PIVOT: mem_raddr = side_base(side_q) +
				(go_upper ? ADDR_W'(0) : ADDR_W'(HALF_ENTRIES));
			ST_SCAN:  mem_raddr = side_base(side_q) + ADDR_W'(nxt);
			default:  mem_raddr = '0;
		endcase
	end

	always_comb begin
		tog_cur = 1'b0;
		for (int s = 0; s < SENSOR_COUNT; s++) begin
			if (1'(s) == side_q) begin
				tog_cur = toggle_q[s];
			end
		end
	end

	assign div_start = (state_q == ST_SCAN) && found && (i_q != '0) && !flat;
	assign div_num   = {8'h00, mem_rdata.fifths} - {8'h00, prev_q.fifths};
	assign div_den   = prev_q.volt - mem_rdata.volt;

	irdti_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			toggle_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && req.req_type == irdti_pkg::REQ_CONVERT && side_ok) begin
						side_q <= req.sensor_side;
						if (cfg.bypass_mode) begin
							dist_q  <= {5'b00000, req.sample};
							state_q <= ST_OUT;
						end else begin
							volt_q  <= volt_in;
							state_q <= ST_PIVOT;
						end
					end
				end
				ST_PIVOT: begin
					// mem_rdata holds the last entry of the upper half
					if (go_upper) begin
						i_q    <= '0;
						last_q <= IDX_W'(HALF_ENTRIES - 1);
					end else begin
						i_q    <= IDX_W'(HALF_ENTRIES);
						last_q <= IDX_W'(ENTRY_COUNT - 1);
						prev_q <= mem_rdata;
					end
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (found) begin
						if (i_q == '0) begin
							dist_q  <= cfg.min_distance_mm;
							state_q <= ST_OUT;
						end else if (flat) begin
							d_q     <= irdti_pkg::DIST_FLAT;
							state_q <= ST_CHK;
						end else begin
							state_q <= ST_DIV;
						end
					end else if (i_q == last_q) begin
						dist_q  <= cfg.infinite_distance_mm;
						state_q <= ST_OUT;
					end else begin
						prev_q <= mem_rdata;
						i_q    <= nxt;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					prod_q  <= xd * div_quo;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					d_q     <= prod_q[15:8] + prev_q.fifths;
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					// d >= max/5 is the same as 5d + 5 > max
					if (({1'b0, d5} + 12'(irdti_pkg::DIST_SCALE)) >
						{1'b0, cfg.max_distance_mm}) begin
						dist_q <= cfg.infinite_distance_mm;
					end else begin
						dist_q <= {4'b0000, d5};
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					// hold until the output register is free
					if (res_load) begin
						for (int s = 0; s < SENSOR_COUNT; s++) begin
							if (1'(s) == side_q) begin
								toggle_q[s] <= ~toggle_q[s];
							end
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q  <= 1'b1;
			res_dist_q   <= dist_q;
			res_toggle_q <= ~tog_cur;
			res_side_q   <= side_q;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.distance_mm = res_dist_q;
	assign res.toggle      = res_toggle_q;
	assign res.result_side = res_side_q;

endmodule

// ----- src/ir_distance_table_interpolator.sv -----
// ---------------------------------------------------------------------------
// ir_distance_table_interpolator
// Calibrated IR distance conversion for up to two sensors.
// ---------------------------------------------------------------------------
// Requests arrive on req (valid/ready). A request with req_type 0 writes one
// calibration entry of the chosen sensor and gives no result; the next request
// may follow at once. A request with req_type 1
// converts sample and gives one result on res: distance_mm, the flipped
// toggle bit of the sensor and result_side.
// Requests are handled one at a time. A table conversion ends in the scan
// with the minimum or infinite answer, or it interpolates: one table read per
// scanned entry through the single read port, then the two-bit-per-cycle
// slope divider, one multiply, and scaling and range check.
// Results sit in an output register; the next request is taken while a
// result waits. If res is stalled, a further conversion holds in its last
// step until the register frees.
// Reset clears the configuration registers to their defaults, the toggle
// bits and the sequencer. The table is not cleared; write each entry before
// a conversion reads it. Configuration writes go through cfg_we, cfg_index
// and cfg_data; the user must make them only while no conversion is in
// flight, as the block itself does not enforce this.
// ---------------------------------------------------------------------------
module ir_distance_table_interpolator #(
	parameter int HALF_ENTRIES = irdti_pkg::HALF_ENTRIES_DEF,
	parameter int SENSOR_COUNT = irdti_pkg::SENSOR_COUNT_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [14:0]  cfg_data,
	irdti_req_if.sink    req,
	irdti_res_if.source  res
);

	localparam int DEPTH  = 2 * HALF_ENTRIES * SENSOR_COUNT;
	localparam int ADDR_W = $clog2(DEPTH);

	irdti_pkg::cfg_t    cfg_q;
	logic               mem_we;
	logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
	irdti_pkg::entry_t  mem_wdata, mem_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.voltage_offset       <= irdti_pkg::RST_VOLTAGE_OFFSET;
			cfg_q.bypass_mode          <= irdti_pkg::RST_BYPASS_MODE;
			cfg_q.min_distance_mm      <= irdti_pkg::RST_MIN_DISTANCE;
			cfg_q.max_distance_mm      <= irdti_pkg::RST_MAX_DISTANCE;
			cfg_q.infinite_distance_mm <= irdti_pkg::RST_INFINITE_DIST;
		end else if (cfg_we) begin
			case (cfg_index)
				irdti_pkg::CFG_VOLTAGE_OFFSET: cfg_q.voltage_offset  <= cfg_data[7:0];
				irdti_pkg::CFG_BYPASS_MODE:    cfg_q.bypass_mode     <= cfg_data[0];
				irdti_pkg::CFG_MIN_DISTANCE:   cfg_q.min_distance_mm <= cfg_data;
				irdti_pkg::CFG_MAX_DISTANCE:   cfg_q.max_distance_mm <= cfg_data[10:0];
				irdti_pkg::CFG_INFINITE_DIST:  cfg_q.infinite_distance_mm <= cfg_data;
				default: ;
			endcase
		end
	end

	irdti_lookup #(
		.HALF_ENTRIES (HALF_ENTRIES),
		.SENSOR_COUNT (SENSOR_COUNT),
		.ADDR_W       (ADDR_W)
	) u_lookup (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.req       (req),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	irdti_table_mem #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

// ----- src/irdti_checker.sv -----
// ---------------------------------------------------------------------------
// irdti_checker
// Port-level checks of the interpolator, bound to the top level.
// ---------------------------------------------------------------------------
`include "ir_distance_table_interpolator_defines.svh"

module irdti_checker #(
	parameter int SENSOR_COUNT = irdti_pkg::SENSOR_COUNT_DEF
) (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        req_type,
	input logic        req_side,
	input logic        res_valid,
	input logic        res_ready,
	input logic [14:0] distance_mm,
	input logic        toggle,
	input logic        result_side
);

	logic req_fire, conv_fire, write_fire;

	assign req_fire   = req_valid && req_ready;
	assign conv_fire  = req_fire && (req_type == irdti_pkg::REQ_CONVERT) &&
		((SENSOR_COUNT > 1) || !req_side);
	assign write_fire = req_fire && (req_type == irdti_pkg::REQ_WRITE);

	`IRDTI_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid,
		"result dropped while stalled")
	`IRDTI_ASSERT_NEXT(a_res_stable, clk, arst_n, res_valid && !res_ready,
		$stable(distance_mm) && $stable(toggle) && $stable(result_side),
		"stalled result changed")
	`IRDTI_ASSERT_NEXT(a_conv_busy, clk, arst_n, conv_fire, !req_ready,
		"conversion did not occupy the sequencer")
	`IRDTI_ASSERT_NEXT(a_write_quiet, clk, arst_n, write_fire && !res_valid, !res_valid,
		"table write produced a result")

endmodule

bind ir_distance_table_interpolator irdti_checker #(
	.SENSOR_COUNT (SENSOR_COUNT)
) u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.req_type    (req.req_type),
	.req_side    (req.sensor_side),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.distance_mm (res.distance_mm),
	.toggle      (res.toggle),
	.result_side (res.result_side)
);

// ----- verif/ir_distance_table_interpolator_tb.sv -----
// ---------------------------------------------------------------------------
// ir_distance_table_interpolator_tb
// Self-checking bench: loads both calibration tables, walks a directed table
// of conversions and register settings, then runs random phases of table
// loads, stray writes and conversions under random source and sink stalls.
// Results are checked against a local predictor or the directed row's values.
// ---------------------------------------------------------------------------
module ir_distance_table_interpolator_tb;

	localparam int HALF           = irdti_pkg::HALF_ENTRIES_DEF;
	localparam int ENTRIES        = 2 * HALF;
	localparam int SIDES          = irdti_pkg::SENSOR_COUNT_DEF;
	localparam int SETTLE_CYCLES  = 40;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASES         = 8;
	localparam int PHASE_ITEMS    = 200;

	localparam logic LEFT  = 1'b0;
	localparam logic RIGHT = 1'b1;

	typedef struct packed {
		logic [14:0] distance_mm;
		logic        toggle;
		logic        result_side;
	} dist_result_t;

	typedef struct packed {
		bit              is_cfg;
		irdti_pkg::cfg_t settings;
		logic            req_type;
		logic            sensor_side;
		logic [3:0]      entry_index;
		logic [7:0]      entry_voltage;
		logic [7:0]      entry_distance;
		logic [9:0]      sample;
		bit              typed;
		logic [14:0]     exp_distance;
		logic            exp_toggle;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [14:0] cfg_data;

	irdti_req_if req_ch ();
	irdti_res_if res_ch ();

	ir_distance_table_interpolator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.res       (res_ch)
	);

	// local copy of the block state
	irdti_pkg::cfg_t   live_cfg;
	irdti_pkg::entry_t cal [SIDES][ENTRIES];
	logic              toggle_bits [SIDES];
	dist_result_t      expected_results [$];
	dist_result_t      head;
	int                mismatches = 0;
	bit                idling_on = 1'b1;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!idling_on || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic irdti_pkg::cfg_t settings(logic [7:0] offset, logic bypass,
		logic [14:0] dmin, logic [10:0] dmax, logic [14:0] dinf);
		irdti_pkg::cfg_t s;
		s.voltage_offset       = offset;
		s.bypass_mode          = bypass;
		s.min_distance_mm      = dmin;
		s.max_distance_mm      = dmax;
		s.infinite_distance_mm = dinf;
		return s;
	endfunction

	function automatic stim_row_t req_row(logic kind, logic side, logic [3:0] idx,
		logic [7:0] volt, logic [7:0] fifths, logic [9:0] sample, bit typed,
		logic [14:0] exp_d, logic exp_t);
		stim_row_t r;
		r = '0;
		r.req_type       = kind;
		r.sensor_side    = side;
		r.entry_index    = idx;
		r.entry_voltage  = volt;
		r.entry_distance = fifths;
		r.sample         = sample;
		r.typed          = typed;
		r.exp_distance   = exp_d;
		r.exp_toggle     = exp_t;
		return r;
	endfunction

	function automatic stim_row_t cfg_row(irdti_pkg::cfg_t s);
		stim_row_t r;
		r = '0;
		r.is_cfg   = 1'b1;
		r.settings = s;
		return r;
	endfunction

	function automatic stim_row_t random_request();
		stim_row_t r;
		r = '0;
		r.req_type       = 1'($urandom_range(0, 1));
		r.sensor_side    = 1'($urandom_range(0, SIDES - 1));
		r.entry_index    = 4'($urandom_range(0, ENTRIES - 1));
		r.entry_voltage  = 8'($urandom_range(0, 255));
		r.entry_distance = 8'($urandom_range(0, 255));
		r.sample         = 10'($urandom_range(0, 1023));
		return r;
	endfunction

	// distance for a table conversion, in the block's widths
	function automatic logic [14:0] predict_distance(logic side, logic [9:0] sample);
		logic [7:0]  volt, pivot, xa, ya, xb, yb, dx, xd, d;
		logic [15:0] rise, slope;
		logic [23:0] quot;
		logic [31:0] prod;
		int          first, last, hit;
		if (int'(sample) > irdti_pkg::SAT_BASE + int'(live_cfg.voltage_offset))
			volt = irdti_pkg::VOLT_SAT;
		else
			volt = sample[8:1] - live_cfg.voltage_offset;
		pivot = cal[side][HALF - 1].volt;
		if (volt > pivot) begin
			first = 0;
			last  = HALF;
		end else begin
			first = HALF;
			last  = ENTRIES;
		end
		hit = -1;
		for (int i = first; i < last && hit < 0; i++)
			if (volt > cal[side][i].volt)
				hit = i;
		if (hit < 0)
			return live_cfg.infinite_distance_mm;
		if (hit == 0)
			return live_cfg.min_distance_mm;
		xa = cal[side][hit - 1].volt;
		ya = cal[side][hit - 1].fifths;
		xb = cal[side][hit].volt;
		yb = cal[side][hit].fifths;
		if (xa == xb) begin
			d = irdti_pkg::DIST_FLAT;
		end else begin
			dx    = xa - xb;
			rise  = {8'd0, yb} - {8'd0, ya};
			quot  = {rise, 8'd0} / {16'd0, dx};
			slope = quot[15:0];
			xd    = xa - volt;
			prod  = {24'd0, xd} * {16'd0, slope};
			d     = prod[15:8] + ya;
		end
		if (int'(d) >= int'(live_cfg.max_distance_mm) / irdti_pkg::DIST_SCALE)
			return live_cfg.infinite_distance_mm;
		return 15'(int'(d) * irdti_pkg::DIST_SCALE);
	endfunction

	// aim samples at table voltages, the saturation edge and the extremes
	function automatic logic [9:0] pick_sample(logic side);
		int x, off;
		off = int'(live_cfg.voltage_offset);
		case ($urandom_range(0, 4))
			0: x = $urandom_range(0, 1023);
			1: x = (int'(cal[side][$urandom_range(0, ENTRIES - 1)].volt) + off) * 2
				+ int'($urandom_range(0, 5)) - 3;
			2: x = irdti_pkg::SAT_BASE + off + int'($urandom_range(0, 2)) - 1;
			3: x = ($urandom_range(0, 1) != 0) ? 1023 : 0;
			default: x = 2 * off + int'($urandom_range(0, 511));
		endcase
		if (x < 0)
			x = 0;
		if (x > 1023)
			x = 1023;
		return x[9:0];
	endfunction

	function automatic irdti_pkg::cfg_t phase_settings(int phase);
		case (phase)
			0: return settings(irdti_pkg::RST_VOLTAGE_OFFSET, irdti_pkg::RST_BYPASS_MODE,
				irdti_pkg::RST_MIN_DISTANCE, irdti_pkg::RST_MAX_DISTANCE,
				irdti_pkg::RST_INFINITE_DIST);
			1: return settings(8'd255, 1'b0, 15'h7fff, 11'd1275, 15'h7fff);
			2: return settings(8'($urandom_range(0, 255)), 1'b1,
				15'($urandom_range(0, 32767)), 11'($urandom_range(0, 1275)),
				15'($urandom_range(0, 32767)));
			3: return settings(8'd0, 1'b0, 15'd0, 11'd0, 15'd0);
			default: return settings(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
				15'($urandom_range(0, 32767)),
				11'(($urandom_range(0, 1) != 0) ? 1275 : $urandom_range(0, 1275)),
				15'($urandom_range(0, 32767)));
		endcase
	endfunction

	task automatic send_request(input stim_row_t it);
		int           gap;
		dist_result_t want;
		gap = pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid          <= 1'b1;
		req_ch.req_type       <= it.req_type;
		req_ch.sensor_side    <= it.sensor_side;
		req_ch.entry_index    <= it.entry_index;
		req_ch.entry_voltage  <= it.entry_voltage;
		req_ch.entry_distance <= it.entry_distance;
		req_ch.sample         <= it.sample;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		// request taken at this edge
		if (it.req_type == irdti_pkg::REQ_WRITE) begin
			cal[it.sensor_side][it.entry_index] = {it.entry_voltage, it.entry_distance};
		end else begin
			toggle_bits[it.sensor_side] = ~toggle_bits[it.sensor_side];
			want.distance_mm = live_cfg.bypass_mode ? {5'd0, it.sample}
				: predict_distance(it.sensor_side, it.sample);
			want.toggle      = toggle_bits[it.sensor_side];
			want.result_side = it.sensor_side;
			if (it.typed) begin
				want.distance_mm = it.exp_distance;
				want.toggle      = it.exp_toggle;
			end
			expected_results.push_back(want);
		end
	endtask

	// hold requests until every result is back, then let in-flight writes finish
	task automatic drain_results();
		req_ch.valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(input irdti_pkg::cfg_idx_t idx, input logic [14:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
	endtask

	task automatic apply_settings(input irdti_pkg::cfg_t s);
		put_reg(irdti_pkg::CFG_VOLTAGE_OFFSET, {7'd0, s.voltage_offset});
		put_reg(irdti_pkg::CFG_BYPASS_MODE, {14'd0, s.bypass_mode});
		put_reg(irdti_pkg::CFG_MIN_DISTANCE, s.min_distance_mm);
		put_reg(irdti_pkg::CFG_MAX_DISTANCE, {4'd0, s.max_distance_mm});
		put_reg(irdti_pkg::CFG_INFINITE_DIST, s.infinite_distance_mm);
		cfg_we   <= 1'b0;
		live_cfg = s;
	endtask

	// descending voltages with mostly rising distances; steps of zero allowed
	task automatic reload_table(input logic side);
		int        v, dv;
		bit        rising;
		stim_row_t it;
		v      = $urandom_range(160, 255);
		dv     = $urandom_range(0, 40);
		rising = ($urandom_range(0, 3) != 0);
		for (int k = 0; k < ENTRIES; k++) begin
			it                = random_request();
			it.req_type       = irdti_pkg::REQ_WRITE;
			it.sensor_side    = side;
			it.entry_index    = 4'(k);
			it.entry_voltage  = 8'(v);
			it.entry_distance = 8'(dv);
			send_request(it);
			v = v - int'($urandom_range(0, 20));
			if (v < 0)
				v = 0;
			if (rising)
				dv = (dv + int'($urandom_range(0, 20)) > 255) ? 255
					: dv + int'($urandom_range(0, 20));
			else
				dv = $urandom_range(0, 255);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_results.size() == 0) begin
				$error("result with no request waiting: distance_mm %0d side %0d",
					res_ch.distance_mm, res_ch.result_side);
				mismatches++;
			end else begin
				head = expected_results.pop_front();
				if (res_ch.distance_mm !== head.distance_mm) begin
					$error("distance_mm: expected %0d, got %0d", head.distance_mm,
						res_ch.distance_mm);
					mismatches++;
				end
				if (res_ch.toggle !== head.toggle) begin
					$error("toggle: expected %0d, got %0d", head.toggle, res_ch.toggle);
					mismatches++;
				end
				if (res_ch.result_side !== head.result_side) begin
					$error("result_side: expected %0d, got %0d", head.result_side,
						res_ch.result_side);
					mismatches++;
				end
			end
		end
	end

	initial begin : receiver
		int run;
		bit level;
		res_ch.ready = 1'b0;
		run   = 0;
		level = 1'b0;
		forever begin
			@(posedge clk);
			if (run == 0) begin
				run   = pick_gap();
				level = (run == 0);
				if (run == 0)
					run = $urandom_range(1, 8);
			end
			res_ch.ready <= level;
			run--;
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("** ir_distance_table_interpolator: FAILED **");
		$finish;
	end

	initial begin : stimulus
		stim_row_t rows [$];
		stim_row_t it;
		int        sent, pick;
		arst_n                = 1'b0;
		cfg_we                = 1'b0;
		cfg_index             = irdti_pkg::CFG_VOLTAGE_OFFSET;
		cfg_data              = '0;
		req_ch.valid          = 1'b0;
		req_ch.req_type       = irdti_pkg::REQ_WRITE;
		req_ch.sensor_side    = LEFT;
		req_ch.entry_index    = '0;
		req_ch.entry_voltage  = '0;
		req_ch.entry_distance = '0;
		req_ch.sample         = '0;
		live_cfg = settings(irdti_pkg::RST_VOLTAGE_OFFSET, irdti_pkg::RST_BYPASS_MODE,
			irdti_pkg::RST_MIN_DISTANCE, irdti_pkg::RST_MAX_DISTANCE,
			irdti_pkg::RST_INFINITE_DIST);
		for (int s = 0; s < SIDES; s++) begin
			toggle_bits[s] = 1'b0;
			for (int k = 0; k < ENTRIES; k++)
				cal[s][k] = '0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill every entry before the first conversion reads one
		for (int k = 0; k < ENTRIES; k++) begin
			send_request(req_row(irdti_pkg::REQ_WRITE, LEFT, 4'(k), 8'(240 - 15 * k),
				8'(10 + 12 * k), 10'd0, 1'b0, 15'd0, 1'b0));
			send_request(req_row(irdti_pkg::REQ_WRITE, RIGHT, 4'(k), 8'(250 - 16 * k),
				8'(5 + 15 * k), 10'd0, 1'b0, 15'd0, 1'b0));
		end

		// saturated sample above the first entry gives the minimum
		rows.push_back(req_row(irdti_pkg::REQ_CONVERT, LEFT, 4'd0, 8'd0, 8'd0, 10'd1023,
			1'b1, irdti_pkg::RST_MIN_DISTANCE, 1'b1));
		// zero voltage below every entry of the lower half
		rows.push_back(req_row(irdti_pkg::REQ_CONVERT, RIGHT, 4'd0, 8'd0, 8'd0, 10'd0,
			1'b1, irdti_pkg::RST_INFINITE_DIST, 1'b1));
		rows.push_back(req_row(irdti_pkg::REQ_CONVERT, LEFT, 4'd0, 8'd0, 8'd0, 10'd1,
			1'b1, irdti_pkg::RST_INFINITE_DIST, 1'b0));
		rows.push_back(req_row(irdti_pkg::REQ_CONVERT, LEFT, 4'd0, 8'd0, 8'd0, 10'd400,
			1'b0, 15'd0, 1'b0));
		// voltage equal to the pivot searches the lower half
		rows.push_back(req_row(irdti_pkg::REQ_CONVERT, LEFT, 4'd0, 8'd0, 8'd0, 10'd270,
			1'b0, 15'd0, 1'b0));
		// just above and at the saturation limit
		rows.push_back(req_row(irdti_pkg::REQ_CONVERT, RIGHT, 4'd0, 8'd0, 8'd0, 10'd511,
			1'b1, irdti_pkg::RST_MIN_DISTANCE, 1'b0));
		rows.push_back(req_row(irdti_pkg::REQ_CONVERT, RIGHT, 4'd0, 8'd0, 8'd0, 10'd510,
			1'b1, irdti_pkg::RST_MIN_DISTANCE, 1'b1));
		rows.push_back(req_row(irdti_pkg::REQ_CONVERT, LEFT, 4'd0, 8'd0, 8'd0, 10'd481,
			1'b0, 15'd0, 1'b0));
		rows.push_back(req_row(irdti_pkg::REQ_CONVERT, LEFT, 4'd0, 8'd0, 8'd0, 10'd21,
			1'b1, irdti_pkg::RST_INFINITE_DIST, 1'b0));
		rows.push_back(req_row(irdti_pkg::REQ_CONVERT, RIGHT, 4'd0, 8'd0, 8'd0, 10'd300,
			1'b0, 15'd0, 1'b0));
		// interpolated value beyond the maximum distance
		rows.push_back(req_row(irdti_pkg::REQ_CONVERT, LEFT, 4'd0, 8'd0, 8'd0, 10'd70,
			1'b0, 15'd0, 1'b0));
		rows.push_back(req_row(irdti_pkg::REQ_WRITE, LEFT, 4'd0, 8'd255, 8'd0, 10'd0,
			1'b0, 15'd0, 1'b0));
		rows.push_back(req_row(irdti_pkg::REQ_CONVERT, LEFT, 4'd0, 8'd0, 8'd0, 10'd1023,
			1'b0, 15'd0, 1'b0));
		rows.push_back(req_row(irdti_pkg::REQ_WRITE, RIGHT, 4'd15, 8'd0, 8'd255, 10'd0,
			1'b0, 15'd0, 1'b0));
		rows.push_back(req_row(irdti_pkg::REQ_CONVERT, RIGHT, 4'd0, 8'd0, 8'd0, 10'd0,
			1'b1, irdti_pkg::RST_INFINITE_DIST, 1'b1));
		rows.push_back(req_row(irdti_pkg::REQ_WRITE, LEFT, 4'd7, 8'd0, 8'd255, 10'd0,
			1'b0, 15'd0, 1'b0));
		rows.push_back(req_row(irdti_pkg::REQ_CONVERT, LEFT, 4'd0, 8'd0, 8'd0, 10'd0,
			1'b1, irdti_pkg::RST_INFINITE_DIST, 1'b1));
		rows.push_back(req_row(irdti_pkg::REQ_CONVERT, LEFT, 4'd0, 8'd0, 8'd0, 10'd2,
			1'b0, 15'd0, 1'b0));
		rows.push_back(cfg_row(settings(irdti_pkg::RST_VOLTAGE_OFFSET, 1'b1,
			irdti_pkg::RST_MIN_DISTANCE, irdti_pkg::RST_MAX_DISTANCE,
			irdti_pkg::RST_INFINITE_DIST)));
		rows.push_back(req_row(irdti_pkg::REQ_CONVERT, RIGHT, 4'd0, 8'd0, 8'd0, 10'd1023,
			1'b1, 15'd1023, 1'b0));
		rows.push_back(req_row(irdti_pkg::REQ_CONVERT, LEFT, 4'd0, 8'd0, 8'd0, 10'd0,
			1'b1, 15'd0, 1'b1));
		rows.push_back(cfg_row(settings(8'd255, 1'b0, 15'h7fff, 11'd1275, 15'h7fff)));
		rows.push_back(req_row(irdti_pkg::REQ_CONVERT, LEFT, 4'd0, 8'd0, 8'd0, 10'd1023,
			1'b0, 15'd0, 1'b0));
		rows.push_back(req_row(irdti_pkg::REQ_CONVERT, RIGHT, 4'd0, 8'd0, 8'd0, 10'd765,
			1'b0, 15'd0, 1'b0));
		// halved sample below the offset wraps around
		rows.push_back(req_row(irdti_pkg::REQ_CONVERT, RIGHT, 4'd0, 8'd0, 8'd0, 10'd100,
			1'b0, 15'd0, 1'b0));
		rows.push_back(cfg_row(settings(8'd0, 1'b0, 15'd0, 11'd0, 15'd0)));
		rows.push_back(req_row(irdti_pkg::REQ_CONVERT, LEFT, 4'd0, 8'd0, 8'd0, 10'd1023,
			1'b1, 15'd0, 1'b1));
		rows.push_back(req_row(irdti_pkg::REQ_CONVERT, RIGHT, 4'd0, 8'd0, 8'd0, 10'd1023,
			1'b1, 15'd0, 1'b1));

		foreach (rows[k]) begin
			if (rows[k].is_cfg) begin
				drain_results();
				apply_settings(rows[k].settings);
			end else begin
				send_request(rows[k]);
			end
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			drain_results();
			apply_settings(phase_settings(phase));
			idling_on = (phase % 4 != 3);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				pick = $urandom_range(0, 99);
				if (pick < 8) begin
					// stray write, may break the descending order
					it = random_request();
					it.req_type = irdti_pkg::REQ_WRITE;
					send_request(it);
					sent++;
				end else if (pick < 14) begin
					reload_table(1'($urandom_range(0, SIDES - 1)));
					sent += ENTRIES;
				end else if (pick < 16) begin
					drain_results();
				end else begin
					it = random_request();
					it.req_type = irdti_pkg::REQ_CONVERT;
					it.sample   = pick_sample(it.sensor_side);
					send_request(it);
					sent++;
				end
			end
		end
		idling_on = 1'b1;

		drain_results();
		if (mismatches == 0 && expected_results.size() == 0)
			$display("** ir_distance_table_interpolator: PASSED **");
		else
			$display("** ir_distance_table_interpolator: FAILED **");
		$finish;
	end

endmodule
